FILE: rtl/assert_macros.svh
// assertion macros shared by the packet buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define PBTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every clock edge, reset included
`define PBTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/pbtd_pkg.sv
// types, constants and helpers for the tail drop packet buffer
package pbtd_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int TIME_WIDTH   = 32;
    localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W        = CNT_W + 1;
    localparam int CFG_W        = 7;
    localparam int CAP_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int BUF_SIZE_RST = 64;

    typedef logic [TIME_WIDTH-1:0] t_time;

    typedef struct packed {
        logic [31:0] arr_tick;
        logic [15:0] svc_ticks;
    } t_in_beat;

    typedef struct packed {
        logic        dropped;
        logic [31:0] start_tick;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic retire;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic expired;
    } t_stat;

    // time values wrap to the time width on entry
    function automatic t_time fit_time(input logic [63:0] v);
        return v[TIME_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/pbtd_ctrl.sv
// sequencer: accepts a beat, walks expired queue entries, then issues the result
`include "assert_macros.svh"

module pbtd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  pbtd_pkg::t_stat i_stat,
    output pbtd_pkg::t_cmd  o_cmd
);
    import pbtd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                // head entry read is in flight
                if (i_stat.count_zero) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_stat.expired) begin
                    o_cmd.retire = 1'b1;
                    n_state      = ST_READ;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // wait for a free output register
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `PBTD_ASSERT(a_accept_reads, (i_in_valid && !o_in_stall) |=> (r_state == ST_READ),
        "accepted beat did not start the queue walk")
    `PBTD_ASSERT(a_commit_shows, o_cmd.commit |=> o_out_valid,
        "committed result not presented")

endmodule

FILE: rtl/pbtd_dp.sv
// datapath: finish time queue, occupancy, last finish time and result register
`include "assert_macros.svh"

module pbtd_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [pbtd_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  pbtd_pkg::t_in_beat          i_in_beat,
    input  pbtd_pkg::t_cmd              i_cmd,
    output pbtd_pkg::t_stat             o_stat,
    output pbtd_pkg::t_out_beat         o_out_beat
);
    import pbtd_pkg::*;

    t_time                 mem [BUFFER_DEPTH];
    t_time                 r_rd_data;
    t_time                 r_arrival;
    t_time                 r_ptime;
    t_time                 r_last_finish, n_last_finish;
    logic [PTR_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CFG_W-1:0]      r_buffer_size;
    t_out_beat             r_out_beat;

    t_time                 in_arrival;
    logic [TIME_WIDTH:0]   finish_sum;
    t_time                 finish;
    logic [CAP_W-1:0]      cap;
    logic                  room;
    logic [SUM_W-1:0]      tail_sum;
    logic [SUM_W-1:0]      tail_wrap;
    logic [PTR_W-1:0]      tail;
    logic [63:0]           start_wide;

    assign in_arrival = fit_time({32'b0, i_in_beat.arr_tick});

    // capacity is the smaller of the register and the queue depth
    assign cap  = (CAP_W'(r_buffer_size) > CAP_W'(BUFFER_DEPTH)) ?
                  CAP_W'(BUFFER_DEPTH) : CAP_W'(r_buffer_size);
    assign room = CAP_W'(r_count) < cap;

    assign finish_sum = {1'b0, r_last_finish} + {1'b0, r_ptime};
    assign finish     = finish_sum[TIME_WIDTH] ? '1 : finish_sum[TIME_WIDTH-1:0];

    assign tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail_wrap = (tail_sum >= SUM_W'(BUFFER_DEPTH)) ?
                       (tail_sum - SUM_W'(BUFFER_DEPTH)) : tail_sum;
    assign tail      = tail_wrap[PTR_W-1:0];

    assign start_wide = 64'(r_last_finish);

    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_last_finish = r_last_finish;
        if (i_cmd.load && (in_arrival > r_last_finish)) begin
            n_last_finish = in_arrival;
        end
        if (i_cmd.retire) begin
            n_head  = (r_head == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (i_cmd.commit && room) begin
            n_last_finish = finish;
            n_count       = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_last_finish <= '0;
            r_buffer_size <= CFG_W'(BUF_SIZE_RST);
        end else begin
            r_head        <= n_head;
            r_count       <= n_count;
            r_last_finish <= n_last_finish;
            if (i_cfg_wr_en) begin
                r_buffer_size <= i_cfg_wr_data;
            end
        end
    end

    // queue storage, read at the head every cycle
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_head];
        if (i_cmd.commit && room) begin
            mem[tail] <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_arrival <= in_arrival;
            r_ptime   <= fit_time({48'b0, i_in_beat.svc_ticks});
        end
        if (i_cmd.commit) begin
            r_out_beat.dropped    <= !room;
            r_out_beat.start_tick <= room ? start_wide[31:0] : 32'b0;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.expired    = (r_arrival >= r_rd_data);
    assign o_out_beat        = r_out_beat;

    `PBTD_ASSERT_ALWAYS(a_count_bound, !i_rst_n || (r_count <= CNT_W'(BUFFER_DEPTH)),
        "queue occupancy above depth")
    `PBTD_ASSERT(a_retire_nonempty, i_cmd.retire |-> (r_count != '0),
        "retire from an empty queue")

endmodule

FILE: rtl/packet_buffer_tail_drop_unit.sv
// top level of the tail drop packet buffer: sequencer plus datapath
//
//  channel  | handshake               | beat
//  ---------+-------------------------+-------------------------------------
//  in       | i_in_valid / o_in_stall | i_in_beat  (arr_tick, svc_ticks)
//  out      | o_out_valid/i_out_stall | o_out_beat (dropped, start_tick)
//  cfg      | i_cfg_wr_en             | i_cfg_wr_data (buffer_size)
//
// an item passes IDLE, READ, CMP unless the queue is empty, and DECIDE, plus
// a READ and CMP for each queued finish time it retires, set by the walk
// over the queue memory, one registered head read then one compare
// reset is synchronous; buffer_size returns to 64 and the queue empties
// the next beat is taken while a result still sits in the output register
// a stalled output holds only the final step of the following item
`include "assert_macros.svh"

module packet_buffer_tail_drop_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [pbtd_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  pbtd_pkg::t_in_beat          i_in_beat,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output pbtd_pkg::t_out_beat         o_out_beat
);
    import pbtd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pbtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pbtd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_beat     (i_in_beat),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_beat    (o_out_beat)
    );

    `PBTD_ASSERT(a_no_commit_on_load, cmd.load |-> !cmd.commit,
        "load and commit in the same cycle")

endmodule
